@@ hdl/indirect_block_path_calc_unit_macros.svh @@
// Assertion macros shared by the block path calculation RTL.
// Included by the module that carries concurrent assertions; needs no package.
`ifndef INDIRECT_BLOCK_PATH_CALC_UNIT_MACROS_SVH
`define INDIRECT_BLOCK_PATH_CALC_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define IBPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define IBPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequence is checked in the next cycle.
`define IBPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ibpc_pkg.sv @@
// Package for the block path calculation unit: constants, path classes and result type.
// Used by ibpc_fields and indirect_block_path_calc_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ibpc_pkg;

   localparam int unsigned DIRECT_SLOTS   = 12;
   localparam int unsigned BLOCK_W        = 32;
   localparam int unsigned SLOT0_W        = 4;
   localparam int unsigned INDEX_W        = 14;
   localparam int unsigned DEPTH_W        = 3;
   localparam int unsigned ADDR_BITS_W    = 4;

   localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_MIN   = 4'd8;
   localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_MAX   = 4'd14;
   localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_RESET = 4'd8;

   // Inode pointer array slots for the indirect trees.
   localparam logic [SLOT0_W-1:0] SLOT_IND  = SLOT0_W'(DIRECT_SLOTS);
   localparam logic [SLOT0_W-1:0] SLOT_DIND = SLOT0_W'(DIRECT_SLOTS + 1);
   localparam logic [SLOT0_W-1:0] SLOT_TIND = SLOT0_W'(DIRECT_SLOTS + 2);

   localparam logic [DEPTH_W-1:0] DEPTH_NONE = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_DIR  = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_IND  = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_DIND = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_TIND = 3'd4;

   // Where a request has been placed so far on its way down the pipeline.
   typedef enum logic [2:0] {
      CLS_PEND   = 3'd0,
      CLS_DIRECT = 3'd1,
      CLS_IND    = 3'd2,
      CLS_DIND   = 3'd3,
      CLS_TIND   = 3'd4,
      CLS_OOR    = 3'd5
   } path_cls_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] path_depth;
      logic [SLOT0_W-1:0] slot_level0;
      logic [INDEX_W-1:0] slot_level1;
      logic [INDEX_W-1:0] slot_level2;
      logic [INDEX_W-1:0] slot_level3;
      logic [INDEX_W-1:0] entries_after;
      logic               out_of_range;
   } path_result_type;

   // Clamp the programmed pointer width into the supported range.
   function automatic logic [ADDR_BITS_W-1:0] eff_bits(input logic [ADDR_BITS_W-1:0] raw);
      logic [ADDR_BITS_W-1:0] b;
      b = raw;
      if (b < ADDR_BITS_MIN) b = ADDR_BITS_MIN;
      if (b > ADDR_BITS_MAX) b = ADDR_BITS_MAX;
      return b;
   endfunction

endpackage

`default_nettype wire

@@ hdl/indirect_block_path_calc_unit.sv @@
// Top level of the block path calculation unit: four-stage mapping pipeline.
// Depends on ibpc_pkg, ibpc_fields and indirect_block_path_calc_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Handshake            Payload
// ----------  ---------  -------------------  -----------------------------------------
// req_        in         req_valid/req_stall  req_logical_block
// rsp_        out        rsp_valid/rsp_stall  path_depth, slot_level0..3, entries_after, oor
// csr_        in         csr_wr_en            csr_wr_data (pointer width, log2)
//
// An accepted request passes through the stage 1, stage 2 and stage 3 registers into
// the result register, and a new request can be accepted in every cycle while the
// pipeline is not stalled; the path runs through the three subtract-and-compare
// stages plus the field extraction stage.
// Reset is synchronous and active high; it empties the pipeline and sets the
// pointer width to 256 entries per block.
// A stall on the response side holds the output register, and stages upstream
// keep filling bubbles until the pipeline is full, so nothing is lost or repeated.

`include "indirect_block_path_calc_unit_macros.svh"

module indirect_block_path_calc_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_logical_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_path_depth,
   output logic [3:0]  rsp_slot_level0,
   output logic [13:0] rsp_slot_level1,
   output logic [13:0] rsp_slot_level2,
   output logic [13:0] rsp_slot_level3,
   output logic [13:0] rsp_entries_after,
   output logic        rsp_out_of_range,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   import ibpc_pkg::*;

   // Configuration register: raw value as written, clamped where stage 1 reads it.
   logic [ADDR_BITS_W-1:0] addr_bits_ff;

   // Stage 1: direct slots removed.
   logic                   v1_ff;
   path_cls_type           cls1_ff, cls1_in;
   logic [BLOCK_W-1:0]     rem1_ff, rem1_in;
   logic [ADDR_BITS_W-1:0] bits1_ff;

   // Stage 2: single-indirect reach removed.
   logic                   v2_ff;
   path_cls_type           cls2_ff, cls2_in;
   logic [BLOCK_W-1:0]     rem2_ff, rem2_in;
   logic [ADDR_BITS_W-1:0] bits2_ff;

   // Stage 3: double-indirect reach removed and the triple reach checked.
   logic                   v3_ff;
   path_cls_type           cls3_ff, cls3_in;
   logic [BLOCK_W-1:0]     rem3_ff, rem3_in;
   logic [ADDR_BITS_W-1:0] bits3_ff;

   // Output register.
   logic                   rsp_valid_ff;
   path_result_type        rsp_ff, rsp_in;

   logic                   en1, en2, en3, en_out;
   logic [BLOCK_W-1:0]     ptrs;
   logic [BLOCK_W-1:0]     dbl;
   logic [BLOCK_W-1:0]     rem_tind;
   logic [5:0]             sh3;

   // Each stage loads when it is empty or when the stage after it loads too.
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en3       = !v3_ff || en_out;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_bits_ff <= ADDR_BITS_RESET;
      end else if (csr_wr_en) begin
         addr_bits_ff <= csr_wr_data;
      end
   end

   // Stage 1: a number below the direct slot count is finished here.
   always_comb begin
      if (req_logical_block < BLOCK_W'(DIRECT_SLOTS)) begin
         cls1_in = CLS_DIRECT;
         rem1_in = req_logical_block;
      end else begin
         cls1_in = CLS_PEND;
         rem1_in = req_logical_block - BLOCK_W'(DIRECT_SLOTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cls1_ff  <= cls1_in;
         rem1_ff  <= rem1_in;
         bits1_ff <= eff_bits(addr_bits_ff);
      end
   end

   // Stage 2: the single-indirect block covers one pointer block of entries.
   assign ptrs = BLOCK_W'(1) << bits1_ff;

   always_comb begin
      cls2_in = cls1_ff;
      rem2_in = rem1_ff;
      if (cls1_ff == CLS_PEND) begin
         if (rem1_ff < ptrs) begin
            cls2_in = CLS_IND;
         end else begin
            rem2_in = rem1_ff - ptrs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         cls2_ff  <= cls2_in;
         rem2_ff  <= rem2_in;
         bits2_ff <= bits1_ff;
      end
   end

   // Stage 3: the double-indirect tree covers the square of the pointer count;
   // what is left must fit under the cube to reach the triple-indirect tree.
   assign dbl      = BLOCK_W'(1) << {bits2_ff, 1'b0};
   assign rem_tind = rem2_ff - dbl;
   assign sh3      = 6'(bits2_ff) + 6'({bits2_ff, 1'b0});

   always_comb begin
      cls3_in = cls2_ff;
      rem3_in = rem2_ff;
      if (cls2_ff == CLS_PEND) begin
         if (rem2_ff < dbl) begin
            cls3_in = CLS_DIND;
         end else begin
            rem3_in = rem_tind;
            if ((rem_tind >> sh3) == '0) begin
               cls3_in = CLS_TIND;
            end else begin
               cls3_in = CLS_OOR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         cls3_ff  <= cls3_in;
         rem3_ff  <= rem3_in;
         bits3_ff <= bits2_ff;
      end
   end

   // Stage 4: split the residual into per-level indexes.
   ibpc_fields u_fields (
      .cls    (cls3_ff),
      .rem    (rem3_ff),
      .bits   (bits3_ff),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_path_depth    = rsp_ff.path_depth;
   assign rsp_slot_level0   = rsp_ff.slot_level0;
   assign rsp_slot_level1   = rsp_ff.slot_level1;
   assign rsp_slot_level2   = rsp_ff.slot_level2;
   assign rsp_slot_level3   = rsp_ff.slot_level3;
   assign rsp_entries_after = rsp_ff.entries_after;
   assign rsp_out_of_range  = rsp_ff.out_of_range;

   // An out-of-range result carries an empty path.
   `IBPC_ASSERT_IMPLY(a_oor_empty, clock, reset, rsp_valid && rsp_out_of_range, rsp_path_depth == DEPTH_NONE && rsp_slot_level0 == '0 && rsp_entries_after == '0, "out-of-range result carries a path")

   // Every result in range has a path of at least one slot.
   `IBPC_ASSERT_IMPLY(a_depth_set, clock, reset, rsp_valid && !rsp_out_of_range, rsp_path_depth != DEPTH_NONE, "in-range result with empty path")

   // A four-level path always starts at the triple-indirect slot.
   `IBPC_ASSERT_IMPLY(a_tind_slot, clock, reset, rsp_valid && rsp_path_depth == DEPTH_TIND, rsp_slot_level0 == SLOT_TIND, "depth four without triple-indirect slot")

   // A full last stage held by the output keeps its contents.
   `IBPC_ASSERT_NEXT(a_stage3_hold, clock, reset, v3_ff && !en_out, v3_ff && $stable(rem3_ff) && $stable(cls3_ff), "stage 3 changed while held")

   // A request taken in lands in the first stage.
   `IBPC_ASSERT_NEXT(a_req_lands, clock, reset, req_valid && !req_stall, v1_ff, "accepted request lost at stage 1")

endmodule

`default_nettype wire

@@ hdl/ibpc_fields.sv @@
// Result field extraction: splits the residual block number into per-level indexes.
// Depends on ibpc_pkg for the path class and the result structure.
`timescale 1ns / 1ps
`default_nettype none

module ibpc_fields (
   input  ibpc_pkg::path_cls_type    cls,
   input  logic [31:0]               rem,
   input  logic [3:0]                bits,
   output ibpc_pkg::path_result_type result
);
   import ibpc_pkg::*;

   logic [INDEX_W-1:0] mask;
   logic [4:0]         sh2;
   logic [INDEX_W-1:0] low_idx;
   logic [INDEX_W-1:0] mid_idx;

   assign mask    = INDEX_W'((15'd1 << bits) - 15'd1);
   assign sh2     = {bits, 1'b0};
   assign low_idx = INDEX_W'(rem) & mask;
   assign mid_idx = INDEX_W'(rem >> bits) & mask;

   always_comb begin
      result = '0;
      case (cls)
         CLS_DIRECT: begin
            result.path_depth    = DEPTH_DIR;
            result.slot_level0   = rem[SLOT0_W-1:0];
            result.entries_after = INDEX_W'(DIRECT_SLOTS - 1)
                                   - {{(INDEX_W-SLOT0_W){1'b0}}, rem[SLOT0_W-1:0]};
         end
         CLS_IND: begin
            result.path_depth    = DEPTH_IND;
            result.slot_level0   = SLOT_IND;
            result.slot_level1   = low_idx;
            result.entries_after = mask - low_idx;
         end
         CLS_DIND: begin
            result.path_depth    = DEPTH_DIND;
            result.slot_level0   = SLOT_DIND;
            result.slot_level1   = INDEX_W'(rem >> bits);
            result.slot_level2   = low_idx;
            result.entries_after = mask - low_idx;
         end
         CLS_TIND: begin
            result.path_depth    = DEPTH_TIND;
            result.slot_level0   = SLOT_TIND;
            result.slot_level1   = INDEX_W'(rem >> sh2);
            result.slot_level2   = mid_idx;
            result.slot_level3   = low_idx;
            result.entries_after = mask - low_idx;
         end
         CLS_OOR: begin
            result.out_of_range = 1'b1;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

`default_nettype wire
